// ===== rtl/ggpc_pkg.sv =====
// Shared constants, codes and the arctangent table of the go-to-goal controller.
// No dependencies; imported by every module of the block.
`default_nettype none
package ggpc_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int POS_W  = 32;   // Q16.16 positions
	localparam int QUAT_W = 16;   // Q1.14 quaternion parts
	localparam int ANG_W  = 16;   // Q3.13 angles
	localparam int CMD_W  = 15;   // Q3.12 gains and limits
	localparam int CRD_W  = 40;   // CORDIC x/y datapath, covers gain growth
	localparam int ZW     = 17;   // CORDIC angle accumulator
	localparam int STEP_W = 6;    // CORDIC and square-root step counter, holds up to 63
	localparam int SQ_W   = 64;   // radicand width
	localparam int ROOT_W = 32;
	localparam int ACC_W  = 68;   // multiply-accumulate register
	localparam int MUL_W  = 18;   // shared multiplier operand width

	localparam logic signed [ZW-1:0] HALF_PI_Q13 = 17'sd12868;
	localparam logic signed [ZW-1:0] PI_Q13      = 17'sd25736;
	localparam logic signed [ZW-1:0] TWO_PI_Q13  = 17'sd51472;

	typedef enum logic [1:0] {
		FUNC_ODOM   = 2'd0,
		FUNC_TICK   = 2'd1,
		FUNC_CANCEL = 2'd2,
		FUNC_START  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_RUNNING   = 2'd0,
		STAT_SUCCEEDED = 2'd1,
		STAT_CANCELED  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CFG_GOAL_X        = 3'd0,
		CFG_GOAL_Y        = 3'd1,
		CFG_ARRIVE_TOL    = 3'd2,
		CFG_LINEAR_GAIN   = 3'd3,
		CFG_LINEAR_LIMIT  = 3'd4,
		CFG_ANGULAR_GAIN  = 3'd5,
		CFG_ANGULAR_LIMIT = 3'd6
	} cfg_idx_t;

	// atan(2^-i) in Q3.13
	function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0:    v = 17'sd6434;
			5'd1:    v = 17'sd3798;
			5'd2:    v = 17'sd2007;
			5'd3:    v = 17'sd1019;
			5'd4:    v = 17'sd511;
			5'd5:    v = 17'sd256;
			5'd6:    v = 17'sd128;
			5'd7:    v = 17'sd64;
			5'd8:    v = 17'sd32;
			5'd9:    v = 17'sd16;
			5'd10:   v = 17'sd8;
			5'd11:   v = 17'sd4;
			5'd12:   v = 17'sd2;
			5'd13:   v = 17'sd1;
			default: v = 17'sd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/go_to_goal_p_controller_top.sv =====
// Go-to-goal proportional controller. Odometry item: quaternion products, then the CORDIC.
// Control tick while navigating: distance products, square root, CORDIC and command
// products, on one shared 18x18 multiplier, the bit-serial square root and the
// iterative CORDIC; cancel or arrival ends after the square root. One item at a time;
// a waiting result does not block the next transfer in. Reset (arst_n, asynchronous)
// clears pose, heading and the navigating flag and loads the register defaults.
`default_nettype none
module go_to_goal_p_controller_top import ggpc_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration write channel
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [2:0]               cfg_index,
	input  wire logic [31:0]              cfg_data,
	// input channel
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [1:0]               func,
	input  wire logic signed [POS_W-1:0]  pos_x,
	input  wire logic signed [POS_W-1:0]  pos_y,
	input  wire logic signed [QUAT_W-1:0] quat_x,
	input  wire logic signed [QUAT_W-1:0] quat_y,
	input  wire logic signed [QUAT_W-1:0] quat_z,
	input  wire logic signed [QUAT_W-1:0] quat_w,
	// result channel
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [CMD_W-1:0]              linear_cmd,
	output logic signed [ANG_W-1:0]       angular_cmd,
	output logic [31:0]                   distance_left,
	output logic [1:0]                    status
);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL_P, S_MUL_A, S_SQRT, S_DECIDE, S_CORDIC, S_OUT
	} state_t;

	typedef enum logic [1:0] {JOB_QUAT, JOB_DIST, JOB_LIN, JOB_ANG} job_t;

	// configuration registers
	logic signed [POS_W-1:0] goal_x_q, goal_y_q;
	logic [30:0]             tol_q;
	logic [CMD_W-1:0]        lin_gain_q, lin_lim_q, ang_gain_q, ang_lim_q;

	// block state and working registers
	state_t                   state_q;
	job_t                     job_q;
	logic [2:0]               step_q;
	logic signed [POS_W-1:0]  pose_x_q, pose_y_q;
	logic signed [ANG_W-1:0]  heading_q;
	logic                     nav_q, cancel_q;
	logic signed [QUAT_W-1:0] qx_q, qy_q, qz_q, qw_q;
	logic signed [POS_W:0]    dx_q, dy_q;
	logic signed [33:0]       s_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [2*MUL_W-1:0] prod_q;
	logic [31:0]              dist_q;
	logic signed [ZW-1:0]     err_q;
	logic [CMD_W-1:0]         res_lin_q;
	logic signed [ANG_W-1:0]  res_ang_q;
	status_t                  res_stat_q;

	// output registers
	logic                     out_valid_q;
	logic [CMD_W-1:0]         lin_out_q;
	logic signed [ANG_W-1:0]  ang_out_q;
	logic [31:0]              dist_out_q;
	status_t                  stat_out_q;

	// datapath nets
	logic [POS_W:0]           ax, ay;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic [5:0]               mul_sh;
	logic                     mul_last;
	logic signed [ACC_W-1:0]  addend, acc_base, acc_sum, ang_sh, lim_ang, lim_lin;
	logic signed [ACC_W-1:0]  c_wide;
	logic                     in_xfer;
	logic                     cord_start, cord_done;
	logic signed [CRD_W-1:0]  cord_y, cord_x;
	logic signed [ANG_W-1:0]  cord_angle;
	logic signed [ZW-1:0]     err_raw, err_wrap;
	logic                     sq_start, sq_done;
	logic [ROOT_W-1:0]        sq_root;
	logic                     arrived;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q   <= '0;
			goal_y_q   <= '0;
			tol_q      <= 31'd6554;
			lin_gain_q <= 15'd2048;
			lin_lim_q  <= 15'd2048;
			ang_gain_q <= 15'd4096;
			ang_lim_q  <= 15'd4096;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GOAL_X:        goal_x_q   <= cfg_data;
				CFG_GOAL_Y:        goal_y_q   <= cfg_data;
				CFG_ARRIVE_TOL:    tol_q      <= cfg_data[30:0];
				CFG_LINEAR_GAIN:   lin_gain_q <= cfg_data[CMD_W-1:0];
				CFG_LINEAR_LIMIT:  lin_lim_q  <= cfg_data[CMD_W-1:0];
				CFG_ANGULAR_GAIN:  ang_gain_q <= cfg_data[CMD_W-1:0];
				CFG_ANGULAR_LIMIT: ang_lim_q  <= cfg_data[CMD_W-1:0];
				default: ;
			endcase
		end
	end

	// magnitudes of the goal offset
	assign ax = dx_q[POS_W] ? (POS_W+1)'(-dx_q) : (POS_W+1)'(dx_q);
	assign ay = dy_q[POS_W] ? (POS_W+1)'(-dy_q) : (POS_W+1)'(dy_q);

	// operand select for the shared multiplier
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		mul_sh   = 6'd0;
		mul_last = 1'b0;
		case (job_q)
			JOB_QUAT: begin
				case (step_q)
					3'd0: begin
						mul_a = {{2{qw_q[15]}}, qw_q};
						mul_b = {{2{qz_q[15]}}, qz_q};
					end
					3'd1: begin
						mul_a = {{2{qx_q[15]}}, qx_q};
						mul_b = {{2{qy_q[15]}}, qy_q};
					end
					3'd2: begin
						mul_a = {{2{qy_q[15]}}, qy_q};
						mul_b = {{2{qy_q[15]}}, qy_q};
					end
					default: begin
						mul_a    = {{2{qz_q[15]}}, qz_q};
						mul_b    = {{2{qz_q[15]}}, qz_q};
						mul_last = 1'b1;
					end
				endcase
			end
			JOB_DIST: begin
				// |d|^2 = hi^2 << 32 + 2 hi lo << 16 + lo^2
				case (step_q)
					3'd0: begin
						mul_a  = {1'b0, ax[32:16]};
						mul_b  = {1'b0, ax[32:16]};
						mul_sh = 6'd32;
					end
					3'd1: begin
						mul_a  = {1'b0, ax[32:16]};
						mul_b  = {2'b00, ax[15:0]};
						mul_sh = 6'd17;
					end
					3'd2: begin
						mul_a = {2'b00, ax[15:0]};
						mul_b = {2'b00, ax[15:0]};
					end
					3'd3: begin
						mul_a  = {1'b0, ay[32:16]};
						mul_b  = {1'b0, ay[32:16]};
						mul_sh = 6'd32;
					end
					3'd4: begin
						mul_a  = {1'b0, ay[32:16]};
						mul_b  = {2'b00, ay[15:0]};
						mul_sh = 6'd17;
					end
					default: begin
						mul_a    = {2'b00, ay[15:0]};
						mul_b    = {2'b00, ay[15:0]};
						mul_last = 1'b1;
					end
				endcase
			end
			JOB_LIN: begin
				mul_a = {3'b000, lin_gain_q};
				if (step_q == 3'd0) begin
					mul_b = {2'b00, dist_q[15:0]};
				end else begin
					mul_b    = {2'b00, dist_q[31:16]};
					mul_last = 1'b1;
				end
			end
			default: begin
				mul_a    = {3'b000, ang_gain_q};
				mul_b    = {err_q[ZW-1], err_q};
				mul_last = 1'b1;
			end
		endcase
	end

	// accumulate path; the linear job drops the low 16 bits between its halves
	always_comb begin
		addend   = {{(ACC_W-2*MUL_W){prod_q[2*MUL_W-1]}}, prod_q} <<< mul_sh;
		acc_base = (job_q == JOB_LIN && step_q != 3'd0) ? (acc_q >>> 16) : acc_q;
		acc_sum  = acc_base + addend;
		c_wide   = 68'sd536870912 - (acc_sum <<< 1);
		ang_sh   = acc_sum >>> 13;
		lim_ang  = {{(ACC_W-CMD_W){1'b0}}, ang_lim_q};
		lim_lin  = {{(ACC_W-CMD_W){1'b0}}, lin_lim_q};
		arrived  = (dist_q <= {1'b0, tol_q});
	end

	// heading error wrapped into plus or minus pi
	always_comb begin
		err_raw = {cord_angle[ANG_W-1], cord_angle} - {heading_q[ANG_W-1], heading_q};
		if (err_raw > PI_Q13) begin
			err_wrap = err_raw - TWO_PI_Q13;
		end else if (err_raw < -PI_Q13) begin
			err_wrap = err_raw + TWO_PI_Q13;
		end else begin
			err_wrap = err_raw;
		end
	end

	// start strobes for the iterative units
	always_comb begin
		cord_start = 1'b0;
		cord_y     = {{(CRD_W-POS_W-1){dy_q[POS_W]}}, dy_q};
		cord_x     = {{(CRD_W-POS_W-1){dx_q[POS_W]}}, dx_q};
		if (state_q == S_MUL_A && job_q == JOB_QUAT && mul_last) begin
			cord_start = 1'b1;
			cord_y     = {{(CRD_W-34){s_q[33]}}, s_q};
			cord_x     = {{(CRD_W-34){c_wide[33]}}, c_wide[33:0]};
		end else if (state_q == S_DECIDE && !cancel_q && !arrived) begin
			cord_start = 1'b1;
		end
		sq_start = (state_q == S_MUL_A) && (job_q == JOB_DIST) && mul_last &&
			(acc_sum[ACC_W-1:SQ_W] == '0);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_q       <= JOB_QUAT;
			step_q      <= '0;
			nav_q       <= 1'b0;
			cancel_q    <= 1'b0;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			heading_q   <= '0;
			qx_q        <= '0;
			qy_q        <= '0;
			qz_q        <= '0;
			qw_q        <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			s_q         <= '0;
			acc_q       <= '0;
			prod_q      <= '0;
			dist_q      <= '0;
			err_q       <= '0;
			res_lin_q   <= '0;
			res_ang_q   <= '0;
			res_stat_q  <= STAT_RUNNING;
			out_valid_q <= 1'b0;
			lin_out_q   <= '0;
			ang_out_q   <= '0;
			dist_out_q  <= '0;
			stat_out_q  <= STAT_RUNNING;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						case (func_t'(func))
							FUNC_ODOM: begin
								pose_x_q <= pos_x;
								pose_y_q <= pos_y;
								qx_q     <= quat_x;
								qy_q     <= quat_y;
								qz_q     <= quat_z;
								qw_q     <= quat_w;
								job_q    <= JOB_QUAT;
								step_q   <= '0;
								acc_q    <= '0;
								state_q  <= S_MUL_P;
							end
							FUNC_START: nav_q <= 1'b1;
							default: begin
								if (nav_q) begin
									cancel_q <= (func_t'(func) == FUNC_CANCEL);
									dx_q     <= {goal_x_q[POS_W-1], goal_x_q} -
										{pose_x_q[POS_W-1], pose_x_q};
									dy_q     <= {goal_y_q[POS_W-1], goal_y_q} -
										{pose_y_q[POS_W-1], pose_y_q};
									job_q    <= JOB_DIST;
									step_q   <= '0;
									acc_q    <= '0;
									state_q  <= S_MUL_P;
								end
							end
						endcase
					end
				end
				S_MUL_P: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_MUL_A;
				end
				S_MUL_A: begin
					acc_q   <= acc_sum;
					step_q  <= step_q + 1'b1;
					state_q <= S_MUL_P;
					if (job_q == JOB_QUAT && step_q == 3'd1) begin
						// sine term done, start the cosine term
						s_q   <= {acc_sum[32:0], 1'b0};
						acc_q <= '0;
					end
					if (mul_last) begin
						case (job_q)
							JOB_QUAT: state_q <= S_CORDIC;
							JOB_DIST: begin
								if (acc_sum[ACC_W-1:SQ_W] != '0) begin
									dist_q  <= '1;
									state_q <= S_DECIDE;
								end else begin
									state_q <= S_SQRT;
								end
							end
							JOB_LIN: begin
								res_lin_q <= (acc_sum > lim_lin) ? lin_lim_q :
									acc_sum[CMD_W-1:0];
								job_q     <= JOB_ANG;
								step_q    <= '0;
								acc_q     <= '0;
							end
							default: begin
								if (ang_sh > lim_ang) begin
									res_ang_q <= {1'b0, ang_lim_q};
								end else if (ang_sh < -lim_ang) begin
									res_ang_q <= -{1'b0, ang_lim_q};
								end else begin
									res_ang_q <= ang_sh[ANG_W-1:0];
								end
								res_stat_q <= STAT_RUNNING;
								state_q    <= S_OUT;
							end
						endcase
					end
				end
				S_SQRT: begin
					if (sq_done) begin
						dist_q  <= sq_root;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (cancel_q) begin
						nav_q      <= 1'b0;
						res_lin_q  <= '0;
						res_ang_q  <= '0;
						res_stat_q <= STAT_CANCELED;
						state_q    <= S_OUT;
					end else if (arrived) begin
						nav_q      <= 1'b0;
						res_lin_q  <= '0;
						res_ang_q  <= '0;
						res_stat_q <= STAT_SUCCEEDED;
						state_q    <= S_OUT;
					end else begin
						state_q <= S_CORDIC;
					end
				end
				S_CORDIC: begin
					if (cord_done) begin
						if (job_q == JOB_QUAT) begin
							heading_q <= cord_angle;
							state_q   <= S_IDLE;
						end else begin
							err_q   <= err_wrap;
							job_q   <= JOB_LIN;
							step_q  <= '0;
							acc_q   <= '0;
							state_q <= S_MUL_P;
						end
					end
				end
				S_OUT: begin
					// load the result once the output slot is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						lin_out_q   <= res_lin_q;
						ang_out_q   <= res_ang_q;
						dist_out_q  <= dist_q;
						stat_out_q  <= res_stat_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ggpc_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.y_in   (cord_y),
		.x_in   (cord_x),
		.done   (cord_done),
		.angle  (cord_angle)
	);

	ggpc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (acc_sum[SQ_W-1:0]),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign out_valid     = out_valid_q;
	assign linear_cmd    = lin_out_q;
	assign angular_cmd   = ang_out_q;
	assign distance_left = dist_out_q;
	assign status        = stat_out_q;

endmodule
`default_nettype wire

// ===== rtl/ggpc_cordic.sv =====
// Iterative CORDIC atan2 in vectoring mode, one micro-rotation per cycle.
// Depends on ggpc_pkg for widths, pi constants and the arctangent table.
`default_nettype none
module ggpc_cordic import ggpc_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [CRD_W-1:0]  y_in,
	input  wire logic signed [CRD_W-1:0]  x_in,
	output logic                          done,
	output logic signed [ANG_W-1:0]       angle
);

	logic signed [CRD_W-1:0] x_q, y_q, xs, ys;
	logic signed [ZW-1:0]    z_q;
	logic [STEP_W-1:0]       cnt_q;
	logic                    busy_q, done_q;
	logic                    step_last;

	// arithmetic shifts round toward minus infinity
	always_comb begin
		xs        = x_q >>> cnt_q;
		ys        = y_q >>> cnt_q;
		step_last = (cnt_q == STEP_W'(CORDIC_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (x_in == 0 && y_in == 0) begin
					// null vector: angle zero
					z_q    <= '0;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					// left half-plane: pre-rotate by a quarter turn
					if (x_in < 0) begin
						if (y_in >= 0) begin
							x_q <= y_in;
							y_q <= -x_in;
							z_q <= HALF_PI_Q13;
						end else begin
							x_q <= -y_in;
							y_q <= x_in;
							z_q <= -HALF_PI_Q13;
						end
					end else begin
						x_q <= x_in;
						y_q <= y_in;
						z_q <= '0;
					end
				end
			end else if (busy_q) begin
				if (y_q >= 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_lut(cnt_q[4:0]);
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_lut(cnt_q[4:0]);
				end
				cnt_q <= cnt_q + 1'b1;
				if (step_last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign angle = z_q[ANG_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/ggpc_isqrt.sv =====
// Bit-serial integer square root (floor), one result bit per cycle.
// Depends on ggpc_pkg for widths.
`default_nettype none
module ggpc_isqrt import ggpc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SQ_W-1:0]   radicand,
	output logic                   done,
	output logic [ROOT_W-1:0]      root
);

	logic [SQ_W-1:0]   rem_q, res_q, bit_q, trial;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q, done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			res_q  <= '0;
			bit_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= radicand;
				res_q  <= '0;
				bit_q  <= {2'b01, {(SQ_W-2){1'b0}}};
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// restoring step: try to take off res + bit
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== dv/go_to_goal_p_controller_top_tb.sv =====
// Self-checking testbench of the go-to-goal proportional controller.
// Depends on rtl/ggpc_pkg.sv and rtl/go_to_goal_p_controller_top.sv.
`timescale 1ns / 1ps
`default_nettype none
module go_to_goal_p_controller_top_tb;
	import ggpc_pkg::*;

	localparam int STEPS = 16;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [CMD_W-1:0]        lin;
		logic signed [ANG_W-1:0] ang;
		logic [31:0]             dleft;
		logic [1:0]              stat;
	} cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic cfg_ready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0;
	logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CMD_W-1:0] linear_cmd;
	logic signed [ANG_W-1:0] angular_cmd;
	logic [31:0] distance_left;
	logic [1:0] status;

	go_to_goal_p_controller_top #(.CORDIC_STEPS(STEPS)) u_dut (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .func, .pos_x, .pos_y, .quat_x, .quat_y, .quat_z, .quat_w,
		.out_valid, .out_stall, .linear_cmd, .angular_cmd, .distance_left, .status
	);

	always #10 clk = ~clk;

	// predictor state
	longint m_goal_x, m_goal_y, m_pose_x, m_pose_y;
	longint m_tol, m_lin_gain, m_lin_lim, m_ang_gain, m_ang_lim;
	longint m_heading;
	bit m_nav;
	cmd_t cmd_queue[$];

	int errors = 0;
	int n_results = 0;
	int n_items = 0;
	int cycles = 0;
	int send_idle = 0, recv_idle = 0;

	function automatic longint atan_q13(int i);
		longint t[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
		return (i < 14) ? t[i] : 0;
	endfunction

	// vectoring CORDIC, floor shifts
	function automatic longint cordic_angle(longint y, longint x);
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = longint'(HALF_PI_Q13);
			end else begin
				x = -y; y = t; z = -longint'(HALF_PI_Q13);
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += atan_q13(i);
			end else begin
				x = x - ys; y = y + xs; z -= atan_q13(i);
			end
		end
		return z;
	endfunction

	function automatic logic [31:0] int_sqrt(logic [63:0] s);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res[31:0];
	endfunction

	function automatic logic [31:0] goal_dist();
		longint dx, dy;
		logic [63:0] a, b, s;
		dx = m_goal_x - m_pose_x;
		dy = m_goal_y - m_pose_y;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		a = dx * dx;
		b = dy * dy;
		s = a + b;
		if (s < a) return 32'hFFFF_FFFF;
		return int_sqrt(s);
	endfunction

	task automatic predict_cmd(logic [1:0] f, logic signed [31:0] px, logic signed [31:0] py,
			logic signed [15:0] qx, logic signed [15:0] qy, logic signed [15:0] qz,
			logic signed [15:0] qw);
		longint s, c, bearing, err, lin, ang;
		logic [31:0] d;
		cmd_t r;
		if (f == FUNC_ODOM) begin
			s = 2 * (longint'(qw) * qz + longint'(qx) * qy);
			c = (longint'(1) << 29) - 2 * (longint'(qy) * qy + longint'(qz) * qz);
			m_pose_x = px;
			m_pose_y = py;
			m_heading = cordic_angle(s, c);
			return;
		end
		if (f == FUNC_START) begin
			m_nav = 1'b1;
			return;
		end
		if (!m_nav) return;
		d = goal_dist();
		r = '0;
		r.dleft = d;
		if (f == FUNC_CANCEL) begin
			m_nav = 1'b0;
			r.stat = STAT_CANCELED;
		end else if (longint'(d) <= m_tol) begin
			m_nav = 1'b0;
			r.stat = STAT_SUCCEEDED;
		end else begin
			bearing = cordic_angle(m_goal_y - m_pose_y, m_goal_x - m_pose_x);
			err = bearing - m_heading;
			while (err > longint'(PI_Q13)) err -= longint'(TWO_PI_Q13);
			while (err < -longint'(PI_Q13)) err += longint'(TWO_PI_Q13);
			lin = (m_lin_gain * longint'(d)) >>> 16;
			if (lin > m_lin_lim) lin = m_lin_lim;
			ang = (m_ang_gain * err) >>> 13;
			if (ang > m_ang_lim) ang = m_ang_lim;
			if (ang < -m_ang_lim) ang = -m_ang_lim;
			r.lin = lin[CMD_W-1:0];
			r.ang = ang[15:0];
			r.stat = STAT_RUNNING;
		end
		cmd_queue.push_back(r);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		if (errors <= 40)
			$display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_results);
	endtask

	// result checker and receiver idling
	always @(posedge clk) begin
		cmd_t w;
		cycles <= cycles + 1;
		if (out_valid && !out_stall) begin
			n_results <= n_results + 1;
			if (cmd_queue.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				w = cmd_queue.pop_front();
				if (linear_cmd !== w.lin) report_mismatch("linear_cmd", linear_cmd, w.lin);
				if (angular_cmd !== w.ang) report_mismatch("angular_cmd", angular_cmd, w.ang);
				if (distance_left !== w.dleft)
					report_mismatch("distance_left", distance_left, w.dleft);
				if (status !== w.stat) report_mismatch("status", status, w.stat);
			end
		end
	end

	always @(negedge clk)
		out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);

	// timeout
	always @(posedge clk)
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_GOAL_X:        m_goal_x = longint'(signed'(val));
			CFG_GOAL_Y:        m_goal_y = longint'(signed'(val));
			CFG_ARRIVE_TOL:    m_tol = val[30:0];
			CFG_LINEAR_GAIN:   m_lin_gain = val[14:0];
			CFG_LINEAR_LIMIT:  m_lin_lim = val[14:0];
			CFG_ANGULAR_GAIN:  m_ang_gain = val[14:0];
			CFG_ANGULAR_LIMIT: m_ang_lim = val[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait for all results, then for the block to finish any item without result
	task automatic drain();
		while (cmd_queue.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic send_item(logic [1:0] f, logic [31:0] px, logic [31:0] py,
			logic [15:0] qx, logic [15:0] qy, logic [15:0] qz, logic [15:0] qw);
		@(negedge clk);
		while ((send_idle > 0) && ($urandom_range(99) < send_idle)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		pos_x <= px; pos_y <= py;
		quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_cmd(f, px, py, qx, qy, qz, qw);
		n_items++;
		// keep valid high for a follow-on item; lowered by the next idle or the end
		fork
			begin
				@(negedge clk);
			end
		join_none
		in_valid <= 1'b1;
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	function automatic logic [15:0] rand_quat();
		case ($urandom_range(3))
			0: return 16'(signed'($urandom_range(32768)) - 16384);
			1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
			2: return 16'($urandom);
			default: return 16'(signed'($urandom_range(2000)) - 1000);
		endcase
	endfunction

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'(signed'($urandom_range(20 << 16)) - (10 << 16));
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'(signed'($urandom_range(8000)) - 4000);
		endcase
	endfunction

	task automatic send_odom(logic [31:0] px, logic [31:0] py);
		send_item(FUNC_ODOM, px, py, rand_quat(), rand_quat(), rand_quat(), rand_quat());
	endtask

	task automatic send_ctl(func_t f);
		send_item(f, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	// directed: extremes, every function, idle cancel/tick, arrival, restart
	task automatic test_directed();
		send_ctl(FUNC_TICK);
		send_ctl(FUNC_CANCEL);
		send_ctl(FUNC_START);
		send_ctl(FUNC_TICK);
		send_ctl(FUNC_START);
		send_ctl(FUNC_START);
		send_ctl(FUNC_CANCEL);
		send_item(FUNC_ODOM, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd16384, -16'sd16384,
			16'sd16384, -16'sd16384);
		send_ctl(FUNC_START);
		send_ctl(FUNC_TICK);
		send_item(FUNC_ODOM, 32'h8000_0000, 32'h7FFF_FFFF, -16'sd16384, 16'sd16384,
			-16'sd16384, 16'sd16384);
		send_ctl(FUNC_TICK);
		send_item(FUNC_ODOM, 0, 0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000);
		send_ctl(FUNC_TICK);
		send_item(FUNC_ODOM, 32'hFFFF_0000, 32'h0, 0, 0, 0, 16'sd16384);
		send_ctl(FUNC_START);
		send_ctl(FUNC_TICK);
		send_ctl(FUNC_CANCEL);
		idle_input();
		drain();
		write_reg(CFG_GOAL_X, 32'h7FFF_FFFF);
		write_reg(CFG_GOAL_Y, 32'h8000_0000);
		write_reg(CFG_ARRIVE_TOL, 32'h7FFF_FFFF);
		write_reg(CFG_LINEAR_GAIN, 32'h7FFF);
		write_reg(CFG_LINEAR_LIMIT, 32'h7FFF);
		write_reg(CFG_ANGULAR_GAIN, 32'h7FFF);
		write_reg(CFG_ANGULAR_LIMIT, 32'h7FFF);
		send_item(FUNC_ODOM, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 16'sd16384);
		send_ctl(FUNC_START);
		send_ctl(FUNC_TICK);
		idle_input();
		drain();
		write_reg(CFG_ARRIVE_TOL, 0);
		idle_input();
		drain();
	endtask

	task automatic random_config();
		write_reg(CFG_GOAL_X, rand_pos());
		write_reg(CFG_GOAL_Y, rand_pos());
		case ($urandom_range(3))
			0: write_reg(CFG_ARRIVE_TOL, 0);
			1: write_reg(CFG_ARRIVE_TOL, 32'h7FFF_FFFF);
			2: write_reg(CFG_ARRIVE_TOL, $urandom);
			default: write_reg(CFG_ARRIVE_TOL, $urandom_range(3 << 16));
		endcase
		write_reg(CFG_LINEAR_GAIN, $urandom_range(1) ? $urandom : $urandom_range(1) * 32'h7FFF);
		write_reg(CFG_LINEAR_LIMIT, $urandom_range(1) ? $urandom : $urandom_range(1) * 32'h7FFF);
		write_reg(CFG_ANGULAR_GAIN, $urandom_range(1) ? $urandom : $urandom_range(1) * 32'h7FFF);
		write_reg(CFG_ANGULAR_LIMIT, $urandom_range(1) ? $urandom : $urandom_range(1) * 32'h7FFF);
	endtask

	// random: mostly start / odometry near goal / ticks, some noise
	task automatic test_random(int count);
		int sent, k;
		sent = 0;
		while (sent < count) begin
			if (sent % 100 == 0) begin
				idle_input();
				drain();
				random_config();
			end
			k = $urandom_range(99);
			if (k < 10) send_ctl(FUNC_START);
			else if (k < 35) begin
				if ($urandom_range(1))
					send_odom(32'(m_goal_x + signed'($urandom_range(8 << 16)) - (4 << 16)),
						32'(m_goal_y + signed'($urandom_range(8 << 16)) - (4 << 16)));
				else
					send_odom(rand_pos(), rand_pos());
			end else if (k < 85) send_ctl(FUNC_TICK);
			else if (k < 92) send_ctl(FUNC_CANCEL);
			else begin
				idle_input();
				repeat ($urandom_range(30)) @(negedge clk);
			end
			sent++;
		end
		idle_input();
		drain();
	endtask

	initial begin
		m_goal_x = 0; m_goal_y = 0; m_pose_x = 0; m_pose_y = 0; m_heading = 0;
		m_tol = 6554; m_lin_gain = 2048; m_lin_lim = 2048;
		m_ang_gain = 4096; m_ang_lim = 4096; m_nav = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_directed();
		send_idle = 16; recv_idle = 80;
		test_random(500);
		send_idle = 80; recv_idle = 16;
		test_random(500);
		send_idle = 0; recv_idle = 0;
		test_random(500);
		repeat (200) @(posedge clk);
		$display("covered %0d items and %0d checked results over several register settings",
			n_items, n_results);
		if (cmd_queue.size() != 0)
			report_mismatch("results missing", 0, cmd_queue.size());
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire
